/* design/stack_expression_evaluator_core_macros.svh */
// ----------------------------------------------------------------------------
// Stack expression evaluator - assertion macros
// Shared property shorthands, clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef STACK_EXPRESSION_EVALUATOR_CORE_MACROS_SVH
`define STACK_EXPRESSION_EVALUATOR_CORE_MACROS_SVH

// same-cycle implication
`define SEE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("see assertion failed");

// next-cycle implication
`define SEE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("see assertion failed");

`endif

/* design/see_pkg.sv */
// ----------------------------------------------------------------------------
// Stack expression evaluator - package
// Sizes, character codes, flag positions and controller/datapath bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package see_pkg;

    localparam int unsigned STACK_DEPTH = 64;
    localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned SYM_W       = 8;
    localparam int unsigned FLAG_W      = 3;

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

    localparam int unsigned FLAG_UNDER = 0;
    localparam int unsigned FLAG_OVER  = 1;
    localparam int unsigned FLAG_DIVZ  = 2;

    typedef struct packed {
        logic load_in;
        logic push_digit;
        logic push_res;
        logic pop_issue;
        logic capt_a;
        logic capt_b;
        logic alu_exec;
        logic div_start;
        logic div_load;
        logic emit;
    } see_cmd_t;

    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_div;
        logic last;
        logic div_done;
        logic out_free;
    } see_stat_t;

endpackage

`default_nettype wire

/* design/see_div.sv */
// ----------------------------------------------------------------------------
// Stack expression evaluator - divider
// Signed 32-bit division, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module see_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [see_pkg::DATA_W-1:0] dividend,
    input  wire logic [see_pkg::DATA_W-1:0] divisor,
    output logic                            done,
    output logic [see_pkg::DATA_W-1:0]      quotient
);

    localparam int unsigned STEP_W = $clog2(see_pkg::DATA_W);

    logic                         busy_reg;
    logic                         done_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [see_pkg::DATA_W-1:0]   rem_reg;
    logic [see_pkg::DATA_W-1:0]   quo_reg;
    logic [see_pkg::DATA_W-1:0]   den_reg;
    logic                         neg_reg;

    logic                         sa;
    logic                         sb;
    logic [see_pkg::DATA_W-1:0]   ua;
    logic [see_pkg::DATA_W-1:0]   ub;
    logic [see_pkg::DATA_W:0]     shifted;
    logic [see_pkg::DATA_W:0]     diff;

    assign sa      = dividend[see_pkg::DATA_W-1];
    assign sb      = divisor[see_pkg::DATA_W-1];
    assign ua      = sa ? (~dividend + 1'b1) : dividend;
    assign ub      = sb ? (~divisor + 1'b1) : divisor;
    assign shifted = {rem_reg, quo_reg[see_pkg::DATA_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                step_reg <= '0;
                den_reg  <= ub;
                if (ub == '0) begin
                    quo_reg  <= '0;
                    neg_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    quo_reg  <= ua;
                    neg_reg  <= sa ^ sb;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg  <= diff[see_pkg::DATA_W] ? shifted[see_pkg::DATA_W-1:0]
                                                  : diff[see_pkg::DATA_W-1:0];
                quo_reg  <= {quo_reg[see_pkg::DATA_W-2:0], ~diff[see_pkg::DATA_W]};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(see_pkg::DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

`default_nettype wire

/* design/see_dp.sv */
// ----------------------------------------------------------------------------
// Stack expression evaluator - datapath
// Operand stack memory, operand and result registers, ALU, flags, output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module see_dp (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wen,
    input  wire logic                       cfg_wdata,
    input  wire logic [see_pkg::SYM_W-1:0]  s_tdata,
    input  wire logic                       s_tlast,
    input  wire see_pkg::see_cmd_t          cmd,
    output see_pkg::see_stat_t              stat,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [see_pkg::DATA_W-1:0]      m_tdata,
    output logic [see_pkg::FLAG_W-1:0]      m_tuser
);

    logic [see_pkg::DATA_W-1:0]  mem [see_pkg::STACK_DEPTH];

    logic                        order_mode_reg;
    logic [see_pkg::SYM_W-1:0]   sym_reg;
    logic                        last_reg;
    logic [see_pkg::CNT_W-1:0]   cnt_reg;
    logic [see_pkg::CNT_W-1:0]   cnt_next;
    logic [see_pkg::FLAG_W-1:0]  flags_reg;
    logic [see_pkg::FLAG_W-1:0]  flags_next;
    logic                        hit_reg;
    logic [see_pkg::DATA_W-1:0]  rd_data_reg;
    logic [see_pkg::DATA_W-1:0]  a_reg;
    logic [see_pkg::DATA_W-1:0]  b_reg;
    logic [see_pkg::DATA_W-1:0]  res_reg;
    logic                        m_tvalid_reg;
    logic [see_pkg::DATA_W-1:0]  m_tdata_reg;
    logic [see_pkg::FLAG_W-1:0]  m_tuser_reg;

    logic                        full;
    logic                        empty;
    logic                        push_en;
    logic [see_pkg::SYM_W-1:0]   digit;
    logic [see_pkg::DATA_W-1:0]  push_val;
    logic [see_pkg::CNT_W-1:0]   cnt_dec;
    logic [see_pkg::DATA_W-1:0]  popped;
    logic [see_pkg::DATA_W-1:0]  lhs;
    logic [see_pkg::DATA_W-1:0]  rhs;
    logic [see_pkg::DATA_W-1:0]  alu_res;
    logic                        div_done;
    logic [see_pkg::DATA_W-1:0]  div_q;

    assign full     = (cnt_reg == see_pkg::CNT_W'(see_pkg::STACK_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign push_en  = cmd.push_digit | cmd.push_res;
    assign digit    = sym_reg - see_pkg::CH_ZERO;
    assign push_val = cmd.push_res ? res_reg
                                   : {{(see_pkg::DATA_W - see_pkg::SYM_W){1'b0}}, digit};
    assign cnt_dec  = cnt_reg - 1'b1;
    assign popped   = hit_reg ? rd_data_reg : '0;
    assign lhs      = order_mode_reg ? a_reg : b_reg;
    assign rhs      = order_mode_reg ? b_reg : a_reg;

    always_comb begin
        case (sym_reg)
            see_pkg::CH_PLUS:  alu_res = lhs + rhs;
            see_pkg::CH_MINUS: alu_res = lhs - rhs;
            see_pkg::CH_STAR:  alu_res = lhs * rhs;
            default:           alu_res = '0;
        endcase
    end

    always_comb begin
        cnt_next   = cnt_reg;
        flags_next = flags_reg;
        if (push_en) begin
            if (full) begin
                flags_next[see_pkg::FLAG_OVER] = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (cmd.pop_issue) begin
            if (empty) begin
                flags_next[see_pkg::FLAG_UNDER] = 1'b1;
            end else begin
                cnt_next = cnt_dec;
            end
        end
        if (cmd.div_start && rhs == '0) begin
            flags_next[see_pkg::FLAG_DIVZ] = 1'b1;
        end
        if (cmd.emit) begin
            cnt_next   = '0;
            flags_next = '0;
        end
    end

    see_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (lhs),
        .divisor  (rhs),
        .done     (div_done),
        .quotient (div_q)
    );

    // stack memory
    always_ff @(posedge aclk) begin
        if (push_en && !full) begin
            mem[cnt_reg[see_pkg::ADDR_W-1:0]] <= push_val;
        end
        if (cmd.pop_issue) begin
            rd_data_reg <= mem[cnt_dec[see_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_mode_reg <= 1'b0;
            cnt_reg        <= '0;
            flags_reg      <= '0;
            hit_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wen) begin
                order_mode_reg <= cfg_wdata;
            end
            cnt_reg   <= cnt_next;
            flags_reg <= flags_next;
            if (cmd.pop_issue) begin
                hit_reg <= !empty;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sym_reg  <= s_tdata;
            last_reg <= s_tlast;
        end
        if (cmd.capt_a) begin
            a_reg <= popped;
        end
        if (cmd.capt_b) begin
            b_reg <= popped;
        end
        if (cmd.alu_exec) begin
            res_reg <= alu_res;
        end else if (cmd.div_load) begin
            res_reg <= div_q;
        end
        if (cmd.emit) begin
            m_tdata_reg <= popped;
            m_tuser_reg <= flags_reg;
        end
    end

    assign stat.is_digit = (sym_reg >= see_pkg::CH_ZERO) && (sym_reg <= see_pkg::CH_NINE);
    assign stat.is_div   = (sym_reg == see_pkg::CH_SLASH);
    assign stat.is_op    = (sym_reg == see_pkg::CH_PLUS) || (sym_reg == see_pkg::CH_MINUS) ||
                           (sym_reg == see_pkg::CH_STAR) || (sym_reg == see_pkg::CH_SLASH);
    assign stat.last     = last_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

/* design/see_ctrl.sv */
// ----------------------------------------------------------------------------
// Stack expression evaluator - controller
// Sequences push, pop, operate and emit steps for one character at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module see_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire see_pkg::see_stat_t  stat,
    output see_pkg::see_cmd_t        cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_PUSH_D = 4'd2;
    localparam logic [3:0] ST_POP1   = 4'd3;
    localparam logic [3:0] ST_POP2   = 4'd4;
    localparam logic [3:0] ST_CAPT   = 4'd5;
    localparam logic [3:0] ST_EXEC   = 4'd6;
    localparam logic [3:0] ST_DIVW   = 4'd7;
    localparam logic [3:0] ST_PUSH_R = 4'd8;
    localparam logic [3:0] ST_FPOP   = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.is_digit) begin
                    state_next = ST_PUSH_D;
                end else if (stat.is_op) begin
                    state_next = ST_POP1;
                end else if (stat.last) begin
                    state_next = ST_FPOP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PUSH_D: begin
                cmd.push_digit = 1'b1;
                state_next     = stat.last ? ST_FPOP : ST_IDLE;
            end
            ST_POP1: begin
                cmd.pop_issue = 1'b1;
                state_next    = ST_POP2;
            end
            ST_POP2: begin
                cmd.capt_a    = 1'b1;
                cmd.pop_issue = 1'b1;
                state_next    = ST_CAPT;
            end
            ST_CAPT: begin
                cmd.capt_b = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (stat.is_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVW;
                end else begin
                    cmd.alu_exec = 1'b1;
                    state_next   = ST_PUSH_R;
                end
            end
            ST_DIVW: begin
                if (stat.div_done) begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_PUSH_R;
                end
            end
            ST_PUSH_R: begin
                cmd.push_res = 1'b1;
                state_next   = stat.last ? ST_FPOP : ST_IDLE;
            end
            ST_FPOP: begin
                cmd.pop_issue = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* design/stack_expression_evaluator_core.sv */
// ----------------------------------------------------------------------------
// Stack expression evaluator - top level
// Postfix / prefix evaluator over a 64-entry stack of 32-bit operands.
// ----------------------------------------------------------------------------
// One character is taken per request and processed before the next is taken.
// A digit is pushed, other non-operator characters are ignored, and + - * / pop
// two operands, one pop a cycle through the registered stack read, and push the
// result; division uses the radix-2 divider, one quotient bit per cycle, and a
// zero divisor yields a zero quotient without iterating. A request marked tlast
// adds the final pop and the result, and waits if the previous result has not
// yet been taken. Stack and flags are cleared with each result.
// order_mode may be written only while no expression is in progress.
`timescale 1ns / 1ps
`default_nettype none

module stack_expression_evaluator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_wdata,  // order_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] symbol
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [31:0] value
    output logic [2:0]       m_tuser     // [0] underflow_seen, [1] overflow_seen,
                                         // [2] div_zero_seen
);

    see_pkg::see_cmd_t  cmd;
    see_pkg::see_stat_t stat;

    see_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    see_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

/* design/see_checker.sv */
// ----------------------------------------------------------------------------
// Stack expression evaluator - port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stack_expression_evaluator_core_macros.svh"

module see_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // a stalled result holds
    `SEE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // each request keeps the block busy for at least the next cycle
    `SEE_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)

    // a result appears only from the emit step, never while input is open
    `SEE_ASSERT_SAME(a_emit_when_busy, $rose(m_tvalid), !$past(s_tready))

    // a last request is never answered in the very next cycle
    `SEE_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready && s_tlast && !m_tvalid, !m_tvalid)

endmodule

bind stack_expression_evaluator_core see_checker u_see_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
